FILE: rtl/core/kau_pkg.sv
// Package for the k-means assign and update unit.
// Holds the shared constants, state encoding and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
package kau_pkg;

  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_POINTS   = 4096;
  localparam int COORD_W      = 24;
  localparam int IDX_W        = 4;
  localparam int NCL_W        = 5;
  localparam int DIST_W       = 49;
  localparam int SQ_W         = 48;
  localparam int SUM_W        = 36;
  localparam int CNT_W        = 13;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 24;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic KIND_ASSIGN   = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLIGHT   = 4'd1;

  localparam logic [NCL_W-1:0]   NUM_CLUSTERS_RST = 5'd2;
  localparam logic [COORD_W-1:0] MAX_FLIGHT_RST   = 24'd320;
  localparam logic [CNT_W-1:0]   CNT_LIMIT        = CNT_W'(MAX_POINTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DRAIN,
    ST_ACCUM,
    ST_UPD_START,
    ST_UPD_WAIT,
    ST_UPD_WRITE,
    ST_CLEAR
  } kau_state_t;

  typedef struct packed {
    logic             accept;
    logic             issue;
    logic             accum;
    logic             upd_start;
    logic             upd_write;
    logic             upd_last;
    logic             clear;
    logic [IDX_W-1:0] idx;
  } kau_cmd_t;

  typedef struct packed {
    logic             fin;
    logic [IDX_W-1:0] k_last;
    logic             pipe_busy;
    logic             count_zero;
    logic             div_done;
  } kau_stat_t;

endpackage

FILE: rtl/core/kau_div.sv
// Two-lane restoring divider, one quotient bit per cycle.
// Divides the x and y sums by a shared member count. Uses kau_pkg.
`timescale 1ns / 1ps
module kau_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [kau_pkg::SUM_W-1:0] dividend_x,
  input  logic [kau_pkg::SUM_W-1:0] dividend_y,
  input  logic [kau_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [kau_pkg::SUM_W-1:0] quot_x,
  output logic [kau_pkg::SUM_W-1:0] quot_y
);
  import kau_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  qx_r, qy_r;
  logic [CNT_W:0]    rx_r, ry_r;
  logic [CNT_W-1:0]  d_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r, done_r;
  logic [CNT_W:0]    tx, ty, sx, sy;
  logic              gx, gy;

  always_comb begin
    tx = {rx_r[CNT_W-1:0], qx_r[SUM_W-1]};
    ty = {ry_r[CNT_W-1:0], qy_r[SUM_W-1]};
    gx = tx >= {1'b0, d_r};
    gy = ty >= {1'b0, d_r};
    sx = gx ? tx - {1'b0, d_r} : tx;
    sy = gy ? ty - {1'b0, d_r} : ty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= run_r && !start && (step_r == STEP_W'(SUM_W - 1));
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qx_r <= dividend_x;
      qy_r <= dividend_y;
      rx_r <= '0;
      ry_r <= '0;
      d_r  <= divisor;
    end else if (run_r) begin
      qx_r <= {qx_r[SUM_W-2:0], gx};
      qy_r <= {qy_r[SUM_W-2:0], gy};
      rx_r <= sx;
      ry_r <= sy;
    end
  end

  assign done   = done_r;
  assign quot_x = qx_r;
  assign quot_y = qy_r;

endmodule

FILE: rtl/core/kau_ctrl.sv
// Controller state machine for the k-means assign and update unit.
// Sequences distance scan, accumulation, centroid update and clear. Uses kau_pkg.
`timescale 1ns / 1ps
module kau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_command,
  input  kau_pkg::kau_stat_t stat,
  output kau_pkg::kau_cmd_t  cmd,
  output logic               busy
);
  import kau_pkg::*;

  kau_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
        if (start && in_command == CMD_POINT) state_nxt = ST_DIST;
      end
      ST_DIST: begin
        if (idx_r == stat.k_last) state_nxt = ST_DRAIN;
        else idx_nxt = idx_r + 1'b1;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        idx_nxt   = '0;
        state_nxt = stat.fin ? ST_UPD_START : ST_IDLE;
      end
      ST_UPD_START: begin
        state_nxt = stat.count_zero ? ST_UPD_WRITE : ST_UPD_WAIT;
      end
      ST_UPD_WAIT: begin
        if (stat.div_done) state_nxt = ST_UPD_WRITE;
      end
      ST_UPD_WRITE: begin
        if (idx_r == stat.k_last) begin
          state_nxt = ST_CLEAR;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_UPD_START;
        end
      end
      ST_CLEAR: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.idx       = idx_r;
    cmd.upd_last  = idx_r == stat.k_last;
    case (state_r)
      ST_IDLE:      cmd.accept    = start;
      ST_DIST:      cmd.issue     = 1'b1;
      ST_ACCUM:     cmd.accum     = 1'b1;
      ST_UPD_START: cmd.upd_start = 1'b1;
      ST_UPD_WRITE: cmd.upd_write = 1'b1;
      ST_CLEAR:     cmd.clear     = 1'b1;
      default:      cmd.accept    = 1'b0;
    endcase
  end

  assign busy = state_r != ST_IDLE;

endmodule

FILE: rtl/core/kau_datapath.sv
// Datapath of the k-means assign and update unit: registers, centroid and sum
// storage, distance pipeline, range check and result register. Uses kau_pkg, kau_div.
`timescale 1ns / 1ps
module kau_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kau_pkg::kau_cmd_t              cmd,
  output kau_pkg::kau_stat_t             stat,
  input  logic                           in_command,
  input  logic [kau_pkg::IDX_W-1:0]      in_cluster_index,
  input  logic [kau_pkg::COORD_W-1:0]    in_coord_x,
  input  logic [kau_pkg::COORD_W-1:0]    in_coord_y,
  input  logic                           in_last_point,
  input  logic                           cfg_write,
  input  logic [kau_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kau_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic                           out_result_kind,
  output logic [kau_pkg::IDX_W-1:0]      out_cluster_id,
  output logic [kau_pkg::DIST_W-1:0]     out_squared_distance,
  output logic [kau_pkg::COORD_W-1:0]    out_centroid_x,
  output logic [kau_pkg::COORD_W-1:0]    out_centroid_y,
  output logic                           out_converged,
  output logic                           out_all_in_range,
  output logic                           out_last
);
  import kau_pkg::*;

  logic [NCL_W-1:0]   ncl_r;
  logic [COORD_W-1:0] maxd_r;
  logic [SQ_W-1:0]    lim_r;

  logic [COORD_W-1:0] cx_r [MAX_CLUSTERS];
  logic [COORD_W-1:0] cy_r [MAX_CLUSTERS];
  logic [SUM_W-1:0]   sx_r [MAX_CLUSTERS];
  logic [SUM_W-1:0]   sy_r [MAX_CLUSTERS];
  logic [CNT_W-1:0]   cnt_r [MAX_CLUSTERS];

  logic [COORD_W-1:0] px_r, py_r;
  logic               fin_r;
  logic               range_r, conv_r;

  logic               v1_r, v2_r;
  logic [IDX_W-1:0]   i1_r, i2_r;
  logic [COORD_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]    qx_r, qy_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [IDX_W-1:0]   best_i_r;

  logic               ov_r, kind_r, conv_out_r, inr_r, last_r;
  logic [IDX_W-1:0]   id_r;
  logic [DIST_W-1:0]  d_out_r;
  logic [COORD_W-1:0] ox_r, oy_r;

  logic [IDX_W-1:0]   sidx;
  logic [IDX_W-1:0]   k_last;
  logic [COORD_W-1:0] ccx, ccy, dx, dy, nx, ny;
  logic [DIST_W-1:0]  d2;
  logic               over, range_nxt, conv_nxt;
  logic               div_done;
  logic [SUM_W-1:0]   qx, qy;

  always_comb begin
    if (ncl_r == '0) k_last = '0;
    else if (ncl_r > NCL_W'(MAX_CLUSTERS)) k_last = IDX_W'(MAX_CLUSTERS - 1);
    else k_last = IDX_W'(ncl_r - 1'b1);
  end

  assign sidx = cmd.accum ? best_i_r : cmd.idx;
  assign ccx  = cx_r[cmd.idx];
  assign ccy  = cy_r[cmd.idx];
  assign dx   = (px_r >= ccx) ? px_r - ccx : ccx - px_r;
  assign dy   = (py_r >= ccy) ? py_r - ccy : ccy - py_r;
  assign d2   = {1'b0, qx_r} + {1'b0, qy_r};

  assign over      = {best_d_r, 2'b00} > {3'b000, lim_r};
  assign range_nxt = range_r | over;
  assign nx        = (cnt_r[sidx] != '0) ? qx[COORD_W-1:0] : ccx;
  assign ny        = (cnt_r[sidx] != '0) ? qy[COORD_W-1:0] : ccy;
  assign conv_nxt  = conv_r & (nx == ccx) & (ny == ccy);

  assign stat.k_last     = k_last;
  assign stat.fin        = fin_r;
  assign stat.pipe_busy  = v1_r | v2_r;
  assign stat.count_zero = cnt_r[sidx] == '0;
  assign stat.div_done   = div_done;

  kau_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.upd_start && cnt_r[sidx] != '0),
    .dividend_x (sx_r[sidx]),
    .dividend_y (sy_r[sidx]),
    .divisor    (cnt_r[sidx]),
    .done       (div_done),
    .quot_x     (qx),
    .quot_y     (qy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncl_r   <= NUM_CLUSTERS_RST;
      maxd_r  <= MAX_FLIGHT_RST;
      range_r <= 1'b0;
      conv_r  <= 1'b1;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      ov_r    <= 1'b0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        cx_r[i]  <= '0;
        cy_r[i]  <= '0;
        sx_r[i]  <= '0;
        sy_r[i]  <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_write && cfg_index == REG_NUM_CLUSTERS) ncl_r <= cfg_data[NCL_W-1:0];
      if (cfg_write && cfg_index == REG_MAX_FLIGHT) maxd_r <= cfg_data;

      if (cmd.accept && in_command == CMD_LOAD) begin
        cx_r[in_cluster_index] <= in_coord_x;
        cy_r[in_cluster_index] <= in_coord_y;
      end

      v1_r <= cmd.issue;
      v2_r <= v1_r;
      ov_r <= cmd.accum | cmd.upd_write;

      if (cmd.accum) begin
        range_r <= range_nxt;
        conv_r  <= 1'b1;
        if (cnt_r[sidx] < CNT_LIMIT) begin
          cnt_r[sidx] <= cnt_r[sidx] + 1'b1;
          sx_r[sidx]  <= sx_r[sidx] + SUM_W'(px_r);
          sy_r[sidx]  <= sy_r[sidx] + SUM_W'(py_r);
        end
      end

      if (cmd.upd_write) begin
        cx_r[cmd.idx] <= nx;
        cy_r[cmd.idx] <= ny;
        conv_r        <= conv_nxt;
      end

      if (cmd.clear) begin
        range_r <= 1'b0;
        for (int i = 0; i < MAX_CLUSTERS; i++) begin
          sx_r[i]  <= '0;
          sy_r[i]  <= '0;
          cnt_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_command == CMD_POINT) begin
      px_r  <= in_coord_x;
      py_r  <= in_coord_y;
      fin_r <= in_last_point;
      lim_r <= maxd_r * maxd_r;
    end
    dx_r <= dx;
    dy_r <= dy;
    i1_r <= cmd.idx;
    qx_r <= dx_r * dx_r;
    qy_r <= dy_r * dy_r;
    i2_r <= i1_r;
    if (v2_r && (i2_r == '0 || d2 < best_d_r)) begin
      best_d_r <= d2;
      best_i_r <= i2_r;
    end
    if (cmd.accum) begin
      kind_r     <= KIND_ASSIGN;
      id_r       <= best_i_r;
      d_out_r    <= best_d_r;
      ox_r       <= '0;
      oy_r       <= '0;
      conv_out_r <= 1'b0;
      inr_r      <= !range_nxt;
      last_r     <= 1'b0;
    end else if (cmd.upd_write) begin
      kind_r     <= KIND_CENTROID;
      id_r       <= cmd.idx;
      d_out_r    <= '0;
      ox_r       <= nx;
      oy_r       <= ny;
      conv_out_r <= cmd.upd_last & conv_nxt;
      inr_r      <= !range_r;
      last_r     <= cmd.upd_last;
    end
  end

  assign out_valid            = ov_r;
  assign out_result_kind      = kind_r;
  assign out_cluster_id       = id_r;
  assign out_squared_distance = d_out_r;
  assign out_centroid_x       = ox_r;
  assign out_centroid_y       = oy_r;
  assign out_converged        = conv_out_r;
  assign out_all_in_range     = inr_r;
  assign out_last             = last_r;

endmodule

FILE: rtl/core/kmeans_assign_update_unit.sv
// Top level of the k-means assign and update unit.
// Joins kau_ctrl and kau_datapath; uses kau_pkg.
//
//  channel  | handshake              | payload
//  input    | start / busy           | in_command, in_cluster_index, in_coord_x/y, in_last_point
//  result   | out_valid strobe       | out_result_kind ... out_last
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A point runs through the shared distance pipeline, which visits one centroid
// per cycle over the k clusters in use. A last point also runs the shared serial
// divider for each cluster with members, then clears the sums and counts.
// Each result is a one-cycle strobe per transfer; the receiver cannot stall.
// Sync active-low reset clears FSM, config and cluster storage; no clearing pass is needed.
`timescale 1ns / 1ps
module kmeans_assign_update_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [kau_pkg::IDX_W-1:0]      in_cluster_index,
  input  logic [kau_pkg::COORD_W-1:0]    in_coord_x,
  input  logic [kau_pkg::COORD_W-1:0]    in_coord_y,
  input  logic                           in_last_point,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kau_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kau_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  output logic                           out_result_kind,
  output logic [kau_pkg::IDX_W-1:0]      out_cluster_id,
  output logic [kau_pkg::DIST_W-1:0]     out_squared_distance,
  output logic [kau_pkg::COORD_W-1:0]    out_centroid_x,
  output logic [kau_pkg::COORD_W-1:0]    out_centroid_y,
  output logic                           out_converged,
  output logic                           out_all_in_range,
  output logic                           out_last
);
  import kau_pkg::*;

  kau_cmd_t  cmd;
  kau_stat_t stat;

  assign cfg_ready = 1'b1;

  kau_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  kau_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_command           (in_command),
    .in_cluster_index     (in_cluster_index),
    .in_coord_x           (in_coord_x),
    .in_coord_y           (in_coord_y),
    .in_last_point        (in_last_point),
    .cfg_write            (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_result_kind      (out_result_kind),
    .out_cluster_id       (out_cluster_id),
    .out_squared_distance (out_squared_distance),
    .out_centroid_x       (out_centroid_x),
    .out_centroid_y       (out_centroid_y),
    .out_converged        (out_converged),
    .out_all_in_range     (out_all_in_range),
    .out_last             (out_last)
  );

`ifndef SYNTHESIS
  a_last_is_centroid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_result_kind == KIND_CENTROID)
    else $error("final result of a pass is not a centroid");

  a_conv_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_converged |-> out_last)
    else $error("converged flag outside the final result");

  a_busy_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start transfer");
`endif

endmodule
